### rtl/imu_cal_pkg.sv
// Shared constants, types and divider reciprocals for the IMU offset calibration block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package imu_cal_pkg;

   // Calibration run length in samples (1 to 1024)
   localparam int CAL_SAMPLES = 500;

   localparam int DATA_W     = 16;
   localparam int AXES       = 6;   // accel x, y, z then gyro x, y, z
   localparam int ACC_Z      = 2;
   localparam int ONE_G      = 16384;
   localparam int THR_W      = 15;
   localparam logic [THR_W-1:0] THR_RESET = 15'd1638;

   // Calibration sums and sample count
   localparam int SUM_W  = 26;
   localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);

   // Sum magnitude divided by CAL_SAMPLES as (mag * DIV_RCP) >> Q_LSB, exact for mag < 2^MAG_W.
   // The product is split into two half-width partial products.
   localparam int MAG_W   = SUM_W;
   localparam int HALF_W  = MAG_W / 2;
   localparam int DIV_L   = $clog2(CAL_SAMPLES);
   localparam int RCP_W   = MAG_W + 1;
   localparam longint unsigned DIV_RCP =
      ((64'd1 << (MAG_W + DIV_L)) + CAL_SAMPLES - 1) / CAL_SAMPLES;
   localparam int PP_W    = HALF_W + RCP_W;
   localparam int PROD_W  = MAG_W + RCP_W + 1;
   localparam int Q_LSB   = MAG_W + DIV_L;

   // Temperature: trunc(raw * 5 / 17) + 3653, in centidegrees
   localparam int TMP_W    = 15;
   localparam int TMP_DIV  = 17;
   localparam int TMP_BIAS = 3653;
   localparam int TMAG_W   = DATA_W + 2;   // |raw| * 5 stays below 2^18
   localparam int TDIV_L   = $clog2(TMP_DIV);
   localparam int TRCP_W   = TMAG_W + 1;
   localparam longint unsigned TDIV_RCP =
      ((64'd1 << (TMAG_W + TDIV_L)) + TMP_DIV - 1) / TMP_DIV;
   localparam int TPROD_W  = TMAG_W + TRCP_W;
   localparam int TQ_LSB   = TMAG_W + TDIV_L;
   localparam int TQ_W     = TPROD_W - TQ_LSB;

   // Squared magnitude: three squares of 16-bit values fit 32 bits
   localparam int SQ_W = 2 * DATA_W;

   typedef logic [AXES-1:0][DATA_W-1:0] axes_type;
   typedef logic [AXES-1:0][SUM_W-1:0]  sums_type;

   // Per-stage advance strobes: an item moves into stage N on sN
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
      logic s8;
   } adv_type;

endpackage

### rtl/imu_cal_if.sv
// Request and response channel interfaces for the IMU offset calibration block.
// Depends on imu_cal_pkg.
`timescale 1ns / 1ps

interface imu_cal_req_if import imu_cal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [DATA_W-1:0] raw_accel_x;
   logic signed [DATA_W-1:0] raw_accel_y;
   logic signed [DATA_W-1:0] raw_accel_z;
   logic signed [DATA_W-1:0] raw_gyro_x;
   logic signed [DATA_W-1:0] raw_gyro_y;
   logic signed [DATA_W-1:0] raw_gyro_z;
   logic signed [DATA_W-1:0] raw_temp;

   modport source (output valid, func, raw_accel_x, raw_accel_y, raw_accel_z,
                   raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_temp, input ready);
   modport sink (input valid, func, raw_accel_x, raw_accel_y, raw_accel_z,
                 raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_temp, output ready);
endinterface

interface imu_cal_rsp_if import imu_cal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] accel_x;
   logic signed [DATA_W-1:0] accel_y;
   logic signed [DATA_W-1:0] accel_z;
   logic signed [DATA_W-1:0] gyro_x;
   logic signed [DATA_W-1:0] gyro_y;
   logic signed [DATA_W-1:0] gyro_z;
   logic signed [TMP_W-1:0]  temp_centi;
   logic                     in_motion;
   logic                     calibrated;
   logic                     cal_done;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   temp_centi, in_motion, calibrated, cal_done, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 temp_centi, in_motion, calibrated, cal_done, output ready);
endinterface

### rtl/imu_cal_accum.sv
// Calibration accumulator: six 26-bit running sums and the sample count.
// Hands the final sums of a completed run to the next stage. Depends on imu_cal_pkg.
`timescale 1ns / 1ps

module imu_cal_accum import imu_cal_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  adv_type  adv,
   input  logic     func_s1,
   input  axes_type raw_s1,
   output sums_type sum_s2,
   output logic     done_s2
);

   sums_type         sum_ff, sum_in, acc;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   sums_type         sum_s2_ff;
   logic             done_s2_ff;

   always_comb begin
      last = (count_ff == CNT_W'(CAL_SAMPLES - 1));
      for (int i = 0; i < AXES; i++) begin
         acc[i] = sum_ff[i] + {{(SUM_W-DATA_W){raw_s1[i][DATA_W-1]}}, raw_s1[i]};
      end
      sum_in   = sum_ff;
      count_in = count_ff;
      if (adv.s2 && func_s1) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = acc;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         sum_s2_ff  <= acc;
         done_s2_ff <= func_s1 && last;
      end
   end

   assign sum_s2  = sum_s2_ff;
   assign done_s2 = done_s2_ff;

endmodule

### rtl/imu_cal_scale.sv
// Constant dividers: sum / CAL_SAMPLES for the offsets and raw temperature to centidegrees.
// Holds the offset registers, committed as a completing beat enters stage 5. Depends on imu_cal_pkg.
`timescale 1ns / 1ps

module imu_cal_scale import imu_cal_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  adv_type                  adv,
   input  sums_type                 sum_s2,
   input  logic                     done_s2,
   input  logic [DATA_W-1:0]        temp_s2,
   output axes_type                 offs,
   output logic                     offs_valid,
   output logic                     done_s5,
   output logic [TMP_W-1:0]         temp_s5
);

   // stage 3: sign and magnitude
   logic [AXES-1:0]            neg_s3_ff;
   logic [AXES-1:0][MAG_W-1:0] mag_s3_ff, mag_in;
   logic                       done_s3_ff;
   logic                       tneg_s3_ff;
   logic [TMAG_W-1:0]          tmag_s3_ff, tmag_in;
   logic [DATA_W-1:0]          tabs;

   // stage 4: partial products
   logic [AXES-1:0]            neg_s4_ff;
   logic [AXES-1:0][PP_W-1:0]  pphi_s4_ff, pplo_s4_ff, pphi_in, pplo_in;
   logic                       done_s4_ff;
   logic                       tneg_s4_ff;
   logic [TPROD_W-1:0]         tprod_s4_ff, tprod_in;

   // stage 5 and offsets
   logic [AXES-1:0][PROD_W-1:0] total;
   axes_type                    mean_in, offs_ff, offs_in;
   logic                        valid_ff, valid_in;
   logic                        done_s5_ff;
   logic [TMP_W-1:0]            temp_s5_ff, temp_in, tq;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         mag_in[i] = sum_s2[i][SUM_W-1] ? -sum_s2[i] : sum_s2[i];
      end
      tabs    = temp_s2[DATA_W-1] ? -temp_s2 : temp_s2;
      tmag_in = ({2'b00, tabs} << 2) + {2'b00, tabs};
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         for (int i = 0; i < AXES; i++) begin
            neg_s3_ff[i] <= sum_s2[i][SUM_W-1];
         end
         mag_s3_ff  <= mag_in;
         done_s3_ff <= done_s2;
         tneg_s3_ff <= temp_s2[DATA_W-1];
         tmag_s3_ff <= tmag_in;
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pplo_in[i] = PP_W'(mag_s3_ff[i][HALF_W-1:0]) * PP_W'(DIV_RCP);
         pphi_in[i] = PP_W'(mag_s3_ff[i][MAG_W-1:HALF_W]) * PP_W'(DIV_RCP);
      end
      tprod_in = TPROD_W'(tmag_s3_ff) * TPROD_W'(TDIV_RCP);
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         neg_s4_ff   <= neg_s3_ff;
         pphi_s4_ff  <= pphi_in;
         pplo_s4_ff  <= pplo_in;
         done_s4_ff  <= done_s3_ff;
         tneg_s4_ff  <= tneg_s3_ff;
         tprod_s4_ff <= tprod_in;
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         total[i]   = (PROD_W'(pphi_s4_ff[i]) << HALF_W) + PROD_W'(pplo_s4_ff[i]);
         mean_in[i] = neg_s4_ff[i] ? -total[i][Q_LSB +: DATA_W]
                                   : total[i][Q_LSB +: DATA_W];
      end
      // Z accel carries gravity: take one g off its offset when the mean is positive, else add one g
      offs_in = mean_in;
      if ($signed(mean_in[ACC_Z]) > $signed(DATA_W'(0))) begin
         offs_in[ACC_Z] = mean_in[ACC_Z] - DATA_W'(ONE_G);
      end else begin
         offs_in[ACC_Z] = mean_in[ACC_Z] + DATA_W'(ONE_G);
      end
      valid_in = valid_ff;
      if (adv.s5 && done_s4_ff) begin
         valid_in = 1'b1;
      end
      tq      = TMP_W'(tprod_s4_ff[TQ_LSB +: TQ_W]);
      temp_in = (tneg_s4_ff ? -tq : tq) + TMP_W'(TMP_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (adv.s5 && done_s4_ff) begin
            offs_ff <= offs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         done_s5_ff <= done_s4_ff;
         temp_s5_ff <= temp_in;
      end
   end

   assign offs       = offs_ff;
   assign offs_valid = valid_ff;
   assign done_s5    = done_s5_ff;
   assign temp_s5    = temp_s5_ff;

endmodule

### rtl/imu_cal_motion.sv
// Offset correction, squared accel magnitude and motion band compare, stages 6 to 8.
// Stage 8 is the result register. Depends on imu_cal_pkg.
`timescale 1ns / 1ps

module imu_cal_motion import imu_cal_pkg::*; (
   input  logic             clock,
   input  adv_type          adv,
   input  axes_type         raw_s5,
   input  logic [TMP_W-1:0] temp_s5,
   input  logic             done_s5,
   input  axes_type         offs,
   input  logic             offs_valid,
   input  logic [THR_W-1:0] threshold,
   output axes_type         cor_s8,
   output logic [TMP_W-1:0] temp_s8,
   output logic             moving_s8,
   output logic             cal_s8,
   output logic             done_s8
);

   axes_type                 cor_s6_ff, cor_in, cor_s7_ff, cor_s8_ff;
   logic [TMP_W-1:0]         temp_s6_ff, temp_s7_ff, temp_s8_ff;
   logic                     cal_s6_ff, cal_s7_ff, cal_s8_ff;
   logic                     done_s6_ff, done_s7_ff, done_s8_ff;
   logic [2:0][SQ_W-1:0]     sq_s7_ff, sq_in;
   logic signed [SQ_W-1:0]   cx [3];
   logic [DATA_W-1:0]        hi, lo;
   logic [SQ_W-1:0]          hi_sq_ff, lo_sq_ff, mag2;
   logic                     lo_en_ff;
   logic                     moving_s8_ff, moving_in;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         cor_in[i] = offs_valid ? raw_s5[i] - offs[i] : raw_s5[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s6) begin
         cor_s6_ff  <= cor_in;
         temp_s6_ff <= temp_s5;
         cal_s6_ff  <= offs_valid;
         done_s6_ff <= done_s5;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cx[k]    = $signed(cor_s6_ff[k]);
         sq_in[k] = SQ_W'(cx[k] * cx[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s7) begin
         cor_s7_ff  <= cor_s6_ff;
         sq_s7_ff   <= sq_in;
         temp_s7_ff <= temp_s6_ff;
         cal_s7_ff  <= cal_s6_ff;
         done_s7_ff <= done_s6_ff;
      end
   end

   // Band limits squared; the user must change threshold only while the pipe is empty, the block does not enforce it
   assign hi = DATA_W'(ONE_G) + DATA_W'(threshold);
   assign lo = DATA_W'(ONE_G) - DATA_W'(threshold);

   always_ff @(posedge clock) begin
      hi_sq_ff <= SQ_W'(hi) * SQ_W'(hi);
      lo_sq_ff <= SQ_W'(lo) * SQ_W'(lo);
      lo_en_ff <= (DATA_W'(threshold) < DATA_W'(ONE_G));
   end

   always_comb begin
      mag2      = sq_s7_ff[0] + sq_s7_ff[1] + sq_s7_ff[2];
      moving_in = (mag2 > hi_sq_ff) || (lo_en_ff && (mag2 < lo_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (adv.s8) begin
         cor_s8_ff    <= cor_s7_ff;
         temp_s8_ff   <= temp_s7_ff;
         moving_s8_ff <= moving_in;
         cal_s8_ff    <= cal_s7_ff;
         done_s8_ff   <= done_s7_ff;
      end
   end

   assign cor_s8    = cor_s8_ff;
   assign temp_s8   = temp_s8_ff;
   assign moving_s8 = moving_s8_ff;
   assign cal_s8    = cal_s8_ff;
   assign done_s8   = done_s8_ff;

endmodule

### rtl/imu_offset_calibration_motion_detect.sv
// Six-axis IMU offset calibration and motion detect, top level.
// Depends on imu_cal_pkg, imu_cal_if, imu_cal_accum, imu_cal_scale, imu_cal_motion.
`timescale 1ns / 1ps

// Accepts one sample set per clock while the response side does not stall and returns
// one result beat per sample, in order. The eight-stage pipeline stalls stage by stage,
// so bubbles close up under backpressure; throughput is set by the response handshake
// alone. Calibration beats (func = 1) add the raw axes into running sums; the beat that
// completes a run of CAL_SAMPLES gets the new offsets already applied and reports
// cal_done. Offsets are committed as that beat enters stage 5, so later beats always
// see them. Write move_threshold only while no beat is in flight.
module imu_offset_calibration_motion_detect import imu_cal_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [THR_W-1:0]  csr_wr_data,
   imu_cal_req_if.sink       req_bus,
   imu_cal_rsp_if.source     rsp_bus
);

   localparam int STAGES = 8;

   logic [STAGES:1]  vld_ff, vld_in, rdy;
   adv_type          adv;
   logic [THR_W-1:0] thr_ff;

   logic              func_s1_ff;
   axes_type          raw_s1_ff, raw_s2_ff, raw_s3_ff, raw_s4_ff, raw_s5_ff;
   logic [DATA_W-1:0] temp_s1_ff, temp_s2_ff;

   sums_type          sum_s2;
   logic              done_s2, done_s5, offs_valid;
   axes_type          offs;
   logic [TMP_W-1:0]  temp_s5, temp_s8;
   axes_type          cor_s8;
   logic              moving_s8, cal_s8, done_s8;

   // Each stage takes a beat when it is empty or its beat moves on
   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_bus.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = rdy[1] ? req_bus.valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
      adv.s2 = vld_ff[1] && rdy[2];
      adv.s3 = vld_ff[2] && rdy[3];
      adv.s4 = vld_ff[3] && rdy[4];
      adv.s5 = vld_ff[4] && rdy[5];
      adv.s6 = vld_ff[5] && rdy[6];
      adv.s7 = vld_ff[6] && rdy[7];
      adv.s8 = vld_ff[7] && rdy[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THR_RESET;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && rdy[1]) begin
         func_s1_ff   <= req_bus.func;
         raw_s1_ff[0] <= req_bus.raw_accel_x;
         raw_s1_ff[1] <= req_bus.raw_accel_y;
         raw_s1_ff[2] <= req_bus.raw_accel_z;
         raw_s1_ff[3] <= req_bus.raw_gyro_x;
         raw_s1_ff[4] <= req_bus.raw_gyro_y;
         raw_s1_ff[5] <= req_bus.raw_gyro_z;
         temp_s1_ff   <= req_bus.raw_temp;
      end
      if (adv.s2) begin
         raw_s2_ff  <= raw_s1_ff;
         temp_s2_ff <= temp_s1_ff;
      end
      if (adv.s3) begin
         raw_s3_ff <= raw_s2_ff;
      end
      if (adv.s4) begin
         raw_s4_ff <= raw_s3_ff;
      end
      if (adv.s5) begin
         raw_s5_ff <= raw_s4_ff;
      end
   end

   imu_cal_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .func_s1 (func_s1_ff),
      .raw_s1  (raw_s1_ff),
      .sum_s2  (sum_s2),
      .done_s2 (done_s2)
   );

   imu_cal_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .sum_s2     (sum_s2),
      .done_s2    (done_s2),
      .temp_s2    (temp_s2_ff),
      .offs       (offs),
      .offs_valid (offs_valid),
      .done_s5    (done_s5),
      .temp_s5    (temp_s5)
   );

   imu_cal_motion u_motion (
      .clock      (clock),
      .adv        (adv),
      .raw_s5     (raw_s5_ff),
      .temp_s5    (temp_s5),
      .done_s5    (done_s5),
      .offs       (offs),
      .offs_valid (offs_valid),
      .threshold  (thr_ff),
      .cor_s8     (cor_s8),
      .temp_s8    (temp_s8),
      .moving_s8  (moving_s8),
      .cal_s8     (cal_s8),
      .done_s8    (done_s8)
   );

   assign req_bus.ready      = rdy[1];
   assign rsp_bus.valid      = vld_ff[STAGES];
   assign rsp_bus.accel_x    = cor_s8[0];
   assign rsp_bus.accel_y    = cor_s8[1];
   assign rsp_bus.accel_z    = cor_s8[2];
   assign rsp_bus.gyro_x     = cor_s8[3];
   assign rsp_bus.gyro_y     = cor_s8[4];
   assign rsp_bus.gyro_z     = cor_s8[5];
   assign rsp_bus.temp_centi = temp_s8;
   assign rsp_bus.in_motion  = moving_s8;
   assign rsp_bus.calibrated = cal_s8;
   assign rsp_bus.cal_done   = done_s8;

   // Once offsets are valid they stay valid until reset
   a_offs_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(offs_valid))
      else $error("offset valid flag dropped");

   // A completing beat sitting in stage 5 has already committed its offsets
   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] && done_s5 |-> offs_valid)
      else $error("completing beat passed stage 5 without committed offsets");

   a_done_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.cal_done |-> rsp_bus.calibrated)
      else $error("cal_done beat not marked calibrated");

endmodule

### dv/testbench.sv
// Self-checking bench for the IMU offset calibration and motion detect block.
// Depends on imu_cal_pkg, imu_cal_if and the top level; predicts every result beat.
`timescale 1ns / 1ps

module testbench;
   import imu_cal_pkg::*;

   localparam int CENTI_BIAS  = 3653;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 24;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 300;

   typedef enum logic {FUNC_MEASURE = 1'b0, FUNC_CAL = 1'b1} sample_func_type;

   typedef struct packed {
      logic              hold;   // wait for all results before sending this beat
      logic              func;
      axes_type          raw;
      logic [DATA_W-1:0] temp;
   } sample_set_type;

   typedef struct packed {
      axes_type         cor;
      logic [TMP_W-1:0] temp_centi;
      logic             moving;
      logic             calibrated;
      logic             cal_done;
   } imu_result_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              csr_en = 1'b0;
   logic [THR_W-1:0]  csr_data = '0;
   logic              send_valid = 1'b0;
   sample_set_type    send_item = '0;
   logic              take_ready = 1'b0;
   int                send_idle_pct = 9;
   int                take_idle_pct = 84;
   int                mismatches = 0;
   int                quiet_cycles = 0;

   sample_set_type    pending_samples [$];
   imu_result_type    expected_results [$];

   // predictor state
   logic [THR_W-1:0]        motion_thr = THR_RESET;
   logic [DATA_W-1:0]       axis_bias [AXES] = '{default: '0};
   logic                    bias_valid = 1'b0;
   logic signed [SUM_W-1:0] run_sum [AXES] = '{default: '0};
   int                      run_count = 0;

   // stimulus shaping: rough copy of the offsets the block will apply
   int bias_guess [AXES] = '{default: 0};
   int run_base [AXES];
   int run_spread [AXES];
   int planned_cal = 0;
   int runs_planned = 0;

   string axis_tag [AXES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

   imu_cal_req_if req_bus ();
   imu_cal_rsp_if rsp_bus ();

   assign req_bus.valid       = send_valid;
   assign req_bus.func        = send_item.func;
   assign req_bus.raw_accel_x = send_item.raw[0];
   assign req_bus.raw_accel_y = send_item.raw[1];
   assign req_bus.raw_accel_z = send_item.raw[2];
   assign req_bus.raw_gyro_x  = send_item.raw[3];
   assign req_bus.raw_gyro_y  = send_item.raw[4];
   assign req_bus.raw_gyro_z  = send_item.raw[5];
   assign req_bus.raw_temp    = send_item.temp;
   assign rsp_bus.ready       = take_ready;

   imu_offset_calibration_motion_detect u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_en),
      .csr_wr_data (csr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic imu_result_type calibrate_and_correct(sample_set_type s);
      imu_result_type r;
      int quotient;
      int centi;
      longint mag2;
      longint hi;
      longint lo;
      logic signed [DATA_W-1:0] c;
      r = '0;
      if (s.func == FUNC_CAL) begin
         for (int i = 0; i < AXES; i++)
            run_sum[i] = run_sum[i] + {{(SUM_W - DATA_W){s.raw[i][DATA_W-1]}}, s.raw[i]};
         run_count++;
         if (run_count >= CAL_SAMPLES) begin
            for (int i = 0; i < AXES; i++) begin
               quotient = run_sum[i];
               quotient = quotient / CAL_SAMPLES;
               axis_bias[i] = quotient[DATA_W-1:0];
            end
            // gravity is taken out of Z; a zero mean counts as not positive
            if ($signed(axis_bias[ACC_Z]) > 0)
               axis_bias[ACC_Z] = axis_bias[ACC_Z] - 16'(ONE_G);
            else
               axis_bias[ACC_Z] = axis_bias[ACC_Z] + 16'(ONE_G);
            bias_valid = 1'b1;
            r.cal_done = 1'b1;
            run_sum = '{default: '0};
            run_count = 0;
         end
      end
      for (int i = 0; i < AXES; i++)
         r.cor[i] = bias_valid ? s.raw[i] - axis_bias[i] : s.raw[i];
      mag2 = 0;
      for (int i = 0; i < 3; i++) begin
         c = r.cor[i];
         mag2 += longint'(c) * longint'(c);
      end
      hi = ONE_G + longint'(motion_thr);
      lo = ONE_G - longint'(motion_thr);
      r.moving = mag2 > hi * hi || (motion_thr < ONE_G && mag2 < lo * lo);
      centi = $signed(s.temp);
      centi = centi * 100 / 340 + CENTI_BIAS;
      r.temp_centi = centi[TMP_W-1:0];
      r.calibrated = bias_valid;
      return r;
   endfunction

   function automatic axes_type pack_axes(int ax, int ay, int az, int gx, int gy, int gz);
      axes_type p;
      p[0] = 16'(ax);
      p[1] = 16'(ay);
      p[2] = 16'(az);
      p[3] = 16'(gx);
      p[4] = 16'(gy);
      p[5] = 16'(gz);
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch %0d at %0d ns: %s got %0d expected %0d",
                  mismatches, $time, what, got, want);
   endtask

   // picks base and spread of the next calibration run; the first three runs give
   // Z a zero, a positive and a negative mean
   task automatic pick_run_content();
      for (int i = 0; i < AXES; i++) begin
         case ($urandom_range(5))
            0: run_base[i] = 0;
            1: run_base[i] = 32767;
            2: run_base[i] = -32768;
            3: run_base[i] = $signed(16'($urandom));
            default: run_base[i] = int'($urandom_range(4000)) - 2000;
         endcase
         case ($urandom_range(3))
            0: run_spread[i] = 0;
            1: run_spread[i] = 20;
            2: run_spread[i] = 800;
            default: run_spread[i] = 20000;
         endcase
      end
      case (runs_planned)
         0: begin
            run_base[ACC_Z] = 0;
            run_spread[ACC_Z] = 0;
         end
         1: begin
            run_base[ACC_Z] = ONE_G + int'($urandom_range(600)) - 300;
            run_spread[ACC_Z] = 200;
         end
         2: begin
            run_base[ACC_Z] = -ONE_G + int'($urandom_range(600)) - 300;
            run_spread[ACC_Z] = 200;
         end
         default: ;
      endcase
      runs_planned++;
   endtask

   task automatic queue_sample(input logic func, input axes_type raw, input int temp,
                               input logic hold);
      sample_set_type s;
      s.hold = hold;
      s.func = func;
      s.raw = raw;
      s.temp = temp[DATA_W-1:0];
      pending_samples.push_back(s);
      if (func == FUNC_CAL) begin
         planned_cal++;
         if (planned_cal == CAL_SAMPLES) begin
            planned_cal = 0;
            for (int i = 0; i < AXES; i++)
               bias_guess[i] = run_base[i];
            bias_guess[ACC_Z] += run_base[ACC_Z] > 0 ? -ONE_G : ONE_G;
            pick_run_content();
         end
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_samples.size() != 0 || send_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      csr_en <= 1'b1;
      csr_data <= value[THR_W-1:0];
      @(posedge clock);
      csr_en <= 1'b0;
      motion_thr = value[THR_W-1:0];
   endtask

   // driver: one beat per handshake, prediction at acceptance
   always @(posedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else begin
         if (send_valid && req_bus.ready)
            expected_results.push_back(calibrate_and_correct(send_item));
         if (!send_valid || req_bus.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!pending_samples[0].hold || expected_results.size() == 0)) begin
               send_item <= pending_samples.pop_front();
               send_valid <= 1'b1;
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      imu_result_type got;
      imu_result_type want;
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && take_ready) begin
            got.cor[0] = rsp_bus.accel_x;
            got.cor[1] = rsp_bus.accel_y;
            got.cor[2] = rsp_bus.accel_z;
            got.cor[3] = rsp_bus.gyro_x;
            got.cor[4] = rsp_bus.gyro_y;
            got.cor[5] = rsp_bus.gyro_z;
            got.temp_centi = rsp_bus.temp_centi;
            got.moving = rsp_bus.in_motion;
            got.calibrated = rsp_bus.calibrated;
            got.cal_done = rsp_bus.cal_done;
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with none expected, accel_x",
                               $signed(got.cor[0]), 0);
            end else begin
               want = expected_results.pop_front();
               for (int i = 0; i < AXES; i++)
                  if (got.cor[i] !== want.cor[i])
                     report_mismatch(axis_tag[i], $signed(got.cor[i]), $signed(want.cor[i]));
               if (got.temp_centi !== want.temp_centi)
                  report_mismatch("temp_centi", $signed(got.temp_centi),
                                  $signed(want.temp_centi));
               if (got.moving !== want.moving)
                  report_mismatch("in_motion", got.moving, want.moving);
               if (got.calibrated !== want.calibrated)
                  report_mismatch("calibrated", got.calibrated, want.calibrated);
               if (got.cal_done !== want.cal_done)
                  report_mismatch("cal_done", got.cal_done, want.cal_done);
            end
         end
         take_ready <= $urandom_range(99) >= take_idle_pct;
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if (reset || (send_valid && req_bus.ready) || (rsp_bus.valid && take_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      axes_type raw;
      int vec [3];
      int v;
      int mag;
      int axis;
      int thr;
      logic hold;
      pick_run_content();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // field extremes and band edges at the reset threshold, offsets still zero
      queue_sample(FUNC_MEASURE, pack_axes(32767, 32767, 32767, 32767, 32767, 32767),
                   32767, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(-32768, -32768, -32768, -32768, -32768, -32768),
                   -32768, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(18022, 0, 0, 1, -1, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(18023, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, -14746, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, 14745, 0, 0, 0), 0, 1'b0);
      // temperature truncates toward zero
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, -16384, 0, 0, 0), -1, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, -16384, 0, 0, 0), -4, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, -16384, 0, 0, 0), 4, 1'b0);
      // first calibration beats; Z stays zero so the run ends with a zero Z mean
      queue_sample(FUNC_CAL, pack_axes(32767, -32768, 0, 32767, -32768, -1), 100, 1'b0);
      queue_sample(FUNC_CAL, pack_axes(-32768, 32767, 0, -32768, 32767, 0), -100, 1'b0);
      queue_sample(FUNC_CAL, pack_axes(1, -1, 0, 0, 1, 32767), 0, 1'b0);

      write_threshold(0);
      queue_sample(FUNC_MEASURE, pack_axes(16384, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, -16385, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, 16383, 0, 0, 0), 0, 1'b0);
      // wide threshold: a small magnitude is never flagged
      write_threshold(16384);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(32767, 32767, 32767, 0, 0, 0), 0, 1'b0);
      write_threshold(16383);
      queue_sample(FUNC_MEASURE, pack_axes(0, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_sample(FUNC_MEASURE, pack_axes(0, 1, 0, 0, 0, 0), 0, 1'b0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: thr = 0;
            1: thr = 16384;
            2: thr = THR_RESET;
            3: thr = $urandom_range(16383, 1);
            4: thr = 16383;
            default: thr = $urandom_range(4000);
         endcase
         write_threshold(thr);
         case (seg / 2)
            0: begin
               send_idle_pct = 9;
               take_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               take_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < SEG_ITEMS; n++) begin
            hold = (seg == 3 && n == 150) || $urandom_range(199) == 0;
            if (n % 8 != 0) begin
               for (int i = 0; i < AXES; i++) begin
                  v = run_base[i] + int'($urandom_range(2 * run_spread[i])) - run_spread[i];
                  if (v > 32767)
                     v = 32767;
                  if (v < -32768)
                     v = -32768;
                  raw[i] = 16'(v);
               end
               queue_sample(FUNC_CAL, raw, $urandom, hold);
            end else begin
               case ($urandom_range(9))
                  0, 1, 2, 3: raw = {$urandom, $urandom, $urandom};
                  9: begin
                     raw = {$urandom, $urandom, $urandom};
                     for (int i = 0; i < 3; i++)
                        raw[i] = 16'(bias_guess[i]);
                  end
                  default: begin
                     // corrected vector close to a band edge
                     axis = $urandom_range(2);
                     case ($urandom_range(2))
                        0: mag = ONE_G + int'(motion_thr) + int'($urandom_range(120)) - 60;
                        1: mag = ONE_G - int'(motion_thr) + int'($urandom_range(120)) - 60;
                        default: mag = ONE_G + int'($urandom_range(400)) - 200;
                     endcase
                     for (int i = 0; i < 3; i++)
                        vec[i] = int'($urandom_range(64)) - 32;
                     vec[axis] = $urandom_range(1) ? mag : -mag;
                     raw = {$urandom, $urandom, $urandom};
                     for (int i = 0; i < 3; i++)
                        raw[i] = 16'(vec[i] + bias_guess[i]);
                  end
               endcase
               queue_sample(FUNC_MEASURE, raw, $urandom, hold);
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
